// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the core modules.
// Every macro samples on i_clk and is muted while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge.
`define ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Check that the consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/lfu_pkg.sv =====
`default_nettype none

package lfu_pkg;

    localparam int DATA_W = 32;
    localparam int CFG_W  = 5;

    localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic accept;   // capture the input word and start the scan
        logic update;   // apply the table update and load the result
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic scan_done;  // last entry compared this cycle
        logic out_busy;   // result register full and not taken
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== rtl/core/lfu_cache_table_core.sv =====
`default_nettype none
// LFU cache table: fully associative key/value store, least-frequently-used
// replacement with ties going to the least recently used entry.
//
// Input channel i_valid/o_ready carries one word: i_operation (0 get,
// 1 put), i_lookup_key and i_write_value. Output channel o_valid/i_ready
// returns one word per input: o_hit, o_read_value (get hit only) and
// o_evicted. The user must set capacity via i_cfg_we/i_cfg_wdata while idle.
//
// The block does not enforce that rule. A new input word is taken only in
// the idle state, once the previous word's update is applied. The key scan
// reads the key and value memories one entry per cycle into registers, and
// the compare stage picks in the same pass the hit, the first free slot and
// the eviction victim. The update state then applies the count, recency and
// store updates and loads the result register.
//
// A result waits in the output register while i_ready is low; the next
// input word is still taken and scanned, and its update holds until the
// waiting result leaves. Reset empties the table and sets capacity to 16.
module lfu_cache_table_core
    import lfu_pkg::*;
#(
    parameter int CAPACITY    = 16,
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_W-1:0]         i_cfg_wdata,
    input  wire logic                     i_valid,
    output logic                          o_ready,
    input  wire logic                     i_operation,
    input  wire logic signed [DATA_W-1:0] i_lookup_key,
    input  wire logic signed [DATA_W-1:0] i_write_value,
    output logic                          o_valid,
    input  wire logic                     i_ready,
    output logic                          o_hit,
    output logic signed [DATA_W-1:0]      o_read_value,
    output logic                          o_evicted
);

    t_dp_cmd           dp_cmd;
    t_dp_sts           dp_sts;
    logic [DATA_W-1:0] read_value;

    // sequence accept, scan and update
    lfu_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (dp_sts),
        .o_cmd   (dp_cmd)
    );

    // table state, scan pipeline and result register
    lfu_datapath #(
        .CAPACITY    (CAPACITY),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_cmd         (dp_cmd),
        .o_sts         (dp_sts),
        .i_operation   (i_operation),
        .i_lookup_key  (i_lookup_key),
        .i_write_value (i_write_value),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_hit         (o_hit),
        .o_read_value  (read_value),
        .o_evicted     (o_evicted)
    );

    assign o_read_value = read_value;

endmodule

`default_nettype wire

// ===== rtl/core/lfu_ctrl.sv =====
`default_nettype none
`include "assert_macros.svh"

module lfu_ctrl
    import lfu_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_ready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (!i_sts.out_busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ready      = 1'b0;
        o_cmd.accept = 1'b0;
        o_cmd.update = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready      = 1'b1;
                o_cmd.accept = i_valid;
            end
            ST_SCAN: begin
            end
            ST_UPDATE: begin
                o_cmd.update = !i_sts.out_busy;
            end
            default: begin
            end
        endcase
    end

    `ASSERT_IMPLY(a_done_in_scan, i_sts.scan_done, r_state == ST_SCAN, "scan done outside scan")
    `ASSERT_NEXT(a_accept_scans, o_cmd.accept, r_state == ST_SCAN, "accept did not start scan")
    `ASSERT_NEXT(a_update_frees, o_cmd.update, o_ready, "update did not return to idle")

endmodule

`default_nettype wire

// ===== rtl/core/lfu_datapath.sv =====
`default_nettype none
`include "assert_macros.svh"

module lfu_datapath
    import lfu_pkg::*;
#(
    parameter int CAPACITY    = 16,
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [CFG_W-1:0]    i_cfg_wdata,
    input  wire t_dp_cmd             i_cmd,
    output t_dp_sts                  o_sts,
    input  wire logic                i_operation,
    input  wire logic [DATA_W-1:0]   i_lookup_key,
    input  wire logic [DATA_W-1:0]   i_write_value,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic                     o_hit,
    output logic [DATA_W-1:0]        o_read_value,
    output logic                     o_evicted
);

    localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int RANK_W = IDX_W;
    localparam int OCC_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (OCC_W > CFG_W) ? OCC_W : CFG_W;
    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(CAPACITY - 1);
    localparam logic [RANK_W-1:0] LAST_RANK = RANK_W'(CAPACITY - 1);

    // key and value stores
    logic [DATA_W-1:0] key_mem [CAPACITY];
    logic [DATA_W-1:0] val_mem [CAPACITY];

    // per-entry state
    logic [CAPACITY-1:0]    r_valid, n_valid;
    logic [COUNT_WIDTH-1:0] r_cnt [CAPACITY];
    logic [COUNT_WIDTH-1:0] n_cnt [CAPACITY];
    logic [RANK_W-1:0]      r_rnk [CAPACITY];
    logic [RANK_W-1:0]      n_rnk [CAPACITY];
    logic [OCC_W-1:0]       r_occ, n_occ;
    logic [CFG_W-1:0]       r_cap_cfg;

    // captured input word
    logic              r_op;
    logic [DATA_W-1:0] r_key_in;
    logic [DATA_W-1:0] r_val_in;

    // scan pipeline
    logic              r_rd_act;
    logic [IDX_W-1:0]  r_rd_idx;
    logic              r_cmp_vld;
    logic [IDX_W-1:0]  r_cmp_idx;
    logic [DATA_W-1:0] r_key_rd;
    logic [DATA_W-1:0] r_val_rd;

    // scan results
    logic                   r_hit;
    logic [IDX_W-1:0]       r_hit_idx;
    logic [RANK_W-1:0]      r_hit_rnk;
    logic [DATA_W-1:0]      r_hit_val;
    logic                   r_free_fnd;
    logic [IDX_W-1:0]       r_free_idx;
    logic                   r_vic_fnd;
    logic [IDX_W-1:0]       r_vic_idx;
    logic [COUNT_WIDTH-1:0] r_vic_cnt;
    logic [RANK_W-1:0]      r_vic_rnk;

    // result register
    logic              r_out_vld;
    logic              r_out_hit;
    logic [DATA_W-1:0] r_out_rd;
    logic              r_out_ev;

    // compare stage view of the scanned entry
    logic                   cmp_v;
    logic [COUNT_WIDTH-1:0] cmp_c;
    logic [RANK_W-1:0]      cmp_k;
    logic                   cmp_better;

    // update decisions
    logic [CMP_W-1:0]  cap_cfg_ext, cap_eff, occ_ext;
    logic              is_put, cap_nz, do_bump, do_ins, evict_ok, ins_ok;
    logic [IDX_W-1:0]  ins_slot;
    logic [RANK_W-1:0] r1;

    always_comb begin
        cap_cfg_ext = CMP_W'(r_cap_cfg);
        cap_eff     = (cap_cfg_ext > CMP_W'(CAPACITY)) ? CMP_W'(CAPACITY) : cap_cfg_ext;
        occ_ext     = CMP_W'(r_occ);
        is_put      = (r_op == OP_PUT);
        cap_nz      = (cap_eff != '0);
        do_bump     = r_hit && (!is_put || cap_nz);
        do_ins      = is_put && cap_nz && !r_hit;
        evict_ok    = do_ins && (occ_ext >= cap_eff) && r_vic_fnd;
        ins_ok      = evict_ok || (do_ins && r_free_fnd);
        ins_slot    = evict_ok ? r_vic_idx : r_free_idx;
    end

    always_comb begin
        cmp_v      = r_valid[r_cmp_idx];
        cmp_c      = r_cnt[r_cmp_idx];
        cmp_k      = r_rnk[r_cmp_idx];
        cmp_better = !r_vic_fnd || (cmp_c < r_vic_cnt) ||
                     ((cmp_c == r_vic_cnt) && (cmp_k > r_vic_rnk));
    end

    // next per-entry state for the update cycle
    always_comb begin
        n_valid = r_valid;
        n_occ   = r_occ;
        r1      = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            n_cnt[i] = r_cnt[i];
            n_rnk[i] = r_rnk[i];
        end
        if (i_cmd.update) begin
            if (do_bump) begin
                for (int i = 0; i < CAPACITY; i++) begin
                    if (IDX_W'(i) == r_hit_idx) begin
                        if (r_cnt[i] != '1) begin
                            n_cnt[i] = r_cnt[i] + 1'b1;
                        end
                        n_rnk[i] = '0;
                    end else if (r_valid[i] && (r_rnk[i] < r_hit_rnk)) begin
                        n_rnk[i] = r_rnk[i] + 1'b1;
                    end
                end
            end
            if (ins_ok) begin
                for (int i = 0; i < CAPACITY; i++) begin
                    if (IDX_W'(i) == ins_slot) begin
                        n_valid[i] = 1'b1;
                        n_cnt[i]   = COUNT_WIDTH'(1);
                        n_rnk[i]   = '0;
                    end else if (r_valid[i]) begin
                        // close the victim's gap, then age behind the newcomer
                        r1 = (evict_ok && (r_rnk[i] > r_vic_rnk)) ? r_rnk[i] - 1'b1
                                                                 : r_rnk[i];
                        n_rnk[i] = (r1 != LAST_RANK) ? r1 + 1'b1 : r1;
                    end
                end
                if (!evict_ok) begin
                    n_occ = r_occ + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_occ     <= '0;
            r_cap_cfg <= CAP_RESET;
            for (int i = 0; i < CAPACITY; i++) begin
                r_cnt[i] <= '0;
                r_rnk[i] <= '0;
            end
        end else begin
            r_valid <= n_valid;
            r_occ   <= n_occ;
            for (int i = 0; i < CAPACITY; i++) begin
                r_cnt[i] <= n_cnt[i];
                r_rnk[i] <= n_rnk[i];
            end
            if (i_cfg_we) begin
                r_cap_cfg <= i_cfg_wdata;
            end
        end
    end

    // memory write and registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.update && ins_ok) begin
            key_mem[ins_slot] <= r_key_in;
            val_mem[ins_slot] <= r_val_in;
        end else if (i_cmd.update && do_bump && is_put) begin
            val_mem[r_hit_idx] <= r_val_in;
        end
        if (r_rd_act) begin
            r_key_rd <= key_mem[r_rd_idx];
            r_val_rd <= val_mem[r_rd_idx];
        end
    end

    // scan address and compare stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_act  <= 1'b0;
            r_rd_idx  <= '0;
            r_cmp_vld <= 1'b0;
            r_cmp_idx <= '0;
        end else begin
            r_cmp_vld <= r_rd_act;
            r_cmp_idx <= r_rd_idx;
            if (i_cmd.accept) begin
                r_rd_act <= 1'b1;
                r_rd_idx <= '0;
            end else if (r_rd_act) begin
                r_rd_act <= (r_rd_idx != LAST_IDX);
                r_rd_idx <= r_rd_idx + 1'b1;
            end
        end
    end

    // capture the input word and track match, free slot and victim
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op       <= i_operation;
            r_key_in   <= i_lookup_key;
            r_val_in   <= i_write_value;
            r_hit      <= 1'b0;
            r_free_fnd <= 1'b0;
            r_vic_fnd  <= 1'b0;
        end else if (r_cmp_vld) begin
            if (cmp_v && (r_key_rd == r_key_in) && !r_hit) begin
                r_hit     <= 1'b1;
                r_hit_idx <= r_cmp_idx;
                r_hit_rnk <= cmp_k;
                r_hit_val <= r_val_rd;
            end
            if (!cmp_v && !r_free_fnd) begin
                r_free_fnd <= 1'b1;
                r_free_idx <= r_cmp_idx;
            end
            if (cmp_v && cmp_better) begin
                r_vic_fnd <= 1'b1;
                r_vic_idx <= r_cmp_idx;
                r_vic_cnt <= cmp_c;
                r_vic_rnk <= cmp_k;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.update) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_out_hit <= r_hit;
            r_out_rd  <= (!is_put && r_hit) ? r_hit_val : '0;
            r_out_ev  <= evict_ok;
        end
    end

    assign o_sts.scan_done = r_cmp_vld && (r_cmp_idx == LAST_IDX);
    assign o_sts.out_busy  = r_out_vld && !i_ready;
    assign o_valid         = r_out_vld;
    assign o_hit           = r_out_hit;
    assign o_read_value    = r_out_rd;
    assign o_evicted       = r_out_ev;

    `ASSERT_ALWAYS(a_occ_count, r_occ == OCC_W'($countones(r_valid)), "occupancy off")
    `ASSERT_ALWAYS(a_occ_bound, r_occ <= OCC_W'(CAPACITY), "occupancy above capacity")
    `ASSERT_IMPLY(a_victim_found, i_cmd.update && do_ins && (occ_ext >= cap_eff), r_vic_fnd,
        "full table without victim")

endmodule

`default_nettype wire

// ===== tb/sv/tb_lfu_cache_table_core.sv =====
`timescale 1ns / 1ps

module tb_lfu_cache_table_core;
    import lfu_pkg::*;

    localparam int DEPTH       = 16;
    localparam int CNT_W       = 16;
    localparam int RANK_W      = 4;
    localparam int POOL_SIZE   = 24;
    localparam int CYCLE_LIMIT = 1000000;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // One result word as the block returns it.
    typedef struct packed {
        logic              hit;
        logic [DATA_W-1:0] read_value;
        logic              evicted;
    } t_lookup_result;

    // Clock, reset and the block's inputs: every input is known from time zero.
    logic                     i_clk         = 1'b0;
    logic                     i_rst_n       = 1'b0;
    logic                     i_cfg_we      = 1'b0;
    logic [CFG_W-1:0]         i_cfg_wdata   = '0;
    logic                     i_valid       = 1'b0;
    logic                     i_operation   = OP_GET;
    logic signed [DATA_W-1:0] i_lookup_key  = '0;
    logic signed [DATA_W-1:0] i_write_value = '0;
    logic                     i_ready       = 1'b0;
    logic                     o_ready;
    logic                     o_valid;
    logic                     o_hit;
    logic signed [DATA_W-1:0] o_read_value;
    logic                     o_evicted;

    // Shadow copy of the cache table, updated once per accepted input word.
    logic [CFG_W-1:0]  capacity_reg;
    logic              slot_live [DEPTH];
    logic [DATA_W-1:0] slot_key  [DEPTH];
    logic [DATA_W-1:0] slot_val  [DEPTH];
    logic [CNT_W-1:0]  slot_uses [DEPTH];
    logic [RANK_W-1:0] slot_age  [DEPTH];
    int                live_count;

    // Results still owed by the block, oldest first.
    t_lookup_result awaited_results [$];

    logic [DATA_W-1:0] key_pool [POOL_SIZE];
    int pool_n;

    int send_idle_pct = 0;
    int recv_idle_pct = 30;
    int n_errors      = 0;
    int n_sent        = 0;
    int n_checked     = 0;
    int n_hits        = 0;
    int n_evictions   = 0;
    int cycle_count   = 0;

    lfu_cache_table_core #(
        .CAPACITY    (DEPTH),
        .COUNT_WIDTH (CNT_W)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_operation   (i_operation),
        .i_lookup_key  (i_lookup_key),
        .i_write_value (i_write_value),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_hit         (o_hit),
        .o_read_value  (o_read_value),
        .o_evicted     (o_evicted)
    );

    // 8 ns period, low first.
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Bump a slot's use count (saturating) and make it the most recent entry.
    function automatic void promote_slot(input int s);
        logic [RANK_W-1:0] r;
        int i;
        r = slot_age[s];
        if (slot_uses[s] != CNT_MAX)
            slot_uses[s]++;
        for (i = 0; i < DEPTH; i++)
            if (slot_live[i] && slot_age[i] < r)
                slot_age[i]++;
        slot_age[s] = '0;
    endfunction

    // Work out the result word of one get or put and advance the shadow table.
    function automatic t_lookup_result table_predict(input logic op,
                                                     input logic [DATA_W-1:0] k,
                                                     input logic [DATA_W-1:0] v);
        t_lookup_result res;
        int lim;
        int slot;
        int victim;
        int free_slot;
        int i;
        logic [RANK_W-1:0] r;
        res  = '0;
        // anything above the table size saturates to the table size
        lim  = (capacity_reg > DEPTH) ? DEPTH : int'(capacity_reg);
        slot = -1;
        for (i = 0; i < DEPTH; i++)
            if (slot < 0 && slot_live[i] && slot_key[i] == k)
                slot = i;
        res.hit = (slot >= 0);

        if (op == OP_GET) begin
            if (slot >= 0) begin
                res.read_value = slot_val[slot];
                promote_slot(slot);
            end
        end else if (lim != 0) begin
            if (slot >= 0) begin
                slot_val[slot] = v;
                promote_slot(slot);
            end else begin
                free_slot = -1;
                if (live_count >= lim) begin
                    // lowest use count loses; on a tie the oldest entry goes
                    victim = -1;
                    for (i = 0; i < DEPTH; i++)
                        if (slot_live[i] && (victim < 0 || slot_uses[i] < slot_uses[victim] ||
                            (slot_uses[i] == slot_uses[victim] &&
                             slot_age[i] > slot_age[victim])))
                            victim = i;
                    if (victim >= 0) begin
                        r = slot_age[victim];
                        slot_live[victim] = 1'b0;
                        slot_uses[victim] = '0;
                        slot_age[victim]  = '0;
                        for (i = 0; i < DEPTH; i++)
                            if (slot_live[i] && slot_age[i] > r)
                                slot_age[i]--;
                        if (live_count > 0)
                            live_count--;
                        free_slot   = victim;
                        res.evicted = 1'b1;
                    end
                end
                if (free_slot < 0)
                    for (i = 0; i < DEPTH; i++)
                        if (free_slot < 0 && !slot_live[i])
                            free_slot = i;
                if (free_slot >= 0) begin
                    for (i = 0; i < DEPTH; i++)
                        if (slot_live[i] && slot_age[i] < DEPTH - 1)
                            slot_age[i]++;
                    slot_live[free_slot] = 1'b1;
                    slot_key[free_slot]  = k;
                    slot_val[free_slot]  = v;
                    slot_uses[free_slot] = CNT_W'(1);
                    slot_age[free_slot]  = '0;
                    live_count++;
                end
            end
        end
        return res;
    endfunction

    // Offer one word, hold it until taken, then log what the block owes for it.
    // Valid stays high after acceptance; the next call either replaces the
    // payload in the same step or drops valid for a gap.
    task automatic issue_word(input logic op, input logic [DATA_W-1:0] k,
                              input logic [DATA_W-1:0] v);
        int n_gap;
        n_gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            n_gap++;
        if (n_gap > 0) begin
            i_valid <= 1'b0;
            repeat (n_gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_operation   <= op;
        i_lookup_key  <= k;
        i_write_value <= v;
        do
            @(posedge i_clk);
        while (!o_ready);
        awaited_results.push_back(table_predict(op, k, v));
        n_sent++;
    endtask

    // Drop valid and hold off until every owed result has been taken.
    task automatic drain_results();
        i_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (awaited_results.size() != 0);
    endtask

    // Write the capacity register with the block idle.
    task automatic write_capacity(input logic [CFG_W-1:0] cap);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= cap;
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        capacity_reg  = cap;
    endtask

    // Extremes of key and value under the reset capacity: fill, hit, miss, update.
    task automatic test_basic_lookup();
        issue_word(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        issue_word(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        issue_word(OP_PUT, 32'h0000_0000, 32'h0000_0000);
        issue_word(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // pause the sender until everything owed has come back
        drain_results();
        issue_word(OP_GET, 32'h8000_0000, 32'hFFFF_FFFF);
        issue_word(OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);
        issue_word(OP_GET, 32'h0000_0000, 32'hFFFF_FFFF);
        issue_word(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        issue_word(OP_GET, 32'h1234_5678, 32'h0000_0000);
        issue_word(OP_PUT, 32'h0000_0000, 32'hA5A5_A5A5);
        issue_word(OP_GET, 32'h0000_0000, 32'h0000_0000);
    endtask

    // Capacity zero: puts change nothing, gets still see stored entries.
    task automatic test_capacity_zero();
        write_capacity(5'd0);
        issue_word(OP_PUT, 32'h0000_0000, 32'h5A5A_5A5A);
        issue_word(OP_PUT, 32'h55AA_55AA, 32'h1111_1111);
        issue_word(OP_GET, 32'h0000_0000, 32'h0000_0000);
        issue_word(OP_GET, 32'h55AA_55AA, 32'h0000_0000);
    endtask

    // Capacity dropped under occupancy: each new key evicts one, ties on recency.
    task automatic test_lowered_capacity();
        write_capacity(5'd2);
        issue_word(OP_PUT, 32'h0000_0100, 32'h0000_0001);
        issue_word(OP_PUT, 32'h0000_0200, 32'h0000_0002);
        issue_word(OP_GET, 32'h0000_0100, 32'h0000_0000);
        issue_word(OP_PUT, 32'h0000_0300, 32'h0000_0003);
        issue_word(OP_GET, 32'h0000_0200, 32'h0000_0000);
        // all ones saturates to the full table
        write_capacity(5'd31);
    endtask

    // Random gets and puts over a key pool one to six keys larger than the capacity,
    // so hits, updates and evictions all occur; a few keys come from the whole range.
    task automatic test_random_traffic(input int send_pct, input int recv_pct);
        int chunk;
        int n_items;
        int eff_cap;
        int i;
        logic [CFG_W-1:0] cap;
        logic [DATA_W-1:0] k;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (i = 0; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;
        for (chunk = 0; chunk < 7; chunk++) begin
            case (chunk)
                0: cap = 5'd16;
                1: cap = 5'd3;
                2: cap = 5'd31;
                3: cap = 5'd1;
                4: cap = 5'd0;
                5: cap = 5'($urandom_range(4, 15));
                default: cap = 5'($urandom_range(17, 30));
            endcase
            write_capacity(cap);
            eff_cap = (cap > DEPTH) ? DEPTH : int'(cap);
            pool_n  = eff_cap + $urandom_range(1, 6);
            if (pool_n > POOL_SIZE)
                pool_n = POOL_SIZE;
            n_items = (cap == 0) ? 30 : 100;
            for (i = 0; i < n_items; i++) begin
                if ($urandom_range(99) < 85)
                    k = key_pool[$urandom_range(pool_n - 1)];
                else
                    k = $urandom;
                issue_word(($urandom_range(99) < 55) ? OP_PUT : OP_GET, k, $urandom);
            end
        end
    endtask

    // Receiver: stall at random; the mix is set per phase.
    always @(posedge i_clk)
        i_ready <= ($urandom_range(99) >= recv_idle_pct);

    // Check each taken result word against the oldest expectation.
    always @(posedge i_clk) begin : check_results
        t_lookup_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (awaited_results.size() == 0) begin
                $display("%0t: result word with none owed: hit %0b read_value %h evicted %0b",
                         $time, o_hit, o_read_value, o_evicted);
                n_errors++;
            end else begin
                want = awaited_results.pop_front();
                n_checked++;
                if (want.hit)
                    n_hits++;
                if (want.evicted)
                    n_evictions++;
                if (o_hit !== want.hit) begin
                    $display("%0t: hit expected %0b actual %0b", $time, want.hit, o_hit);
                    n_errors++;
                end
                if (o_read_value !== want.read_value) begin
                    $display("%0t: read_value expected %h actual %h",
                             $time, want.read_value, o_read_value);
                    n_errors++;
                end
                if (o_evicted !== want.evicted) begin
                    $display("%0t: evicted expected %0b actual %0b",
                             $time, want.evicted, o_evicted);
                    n_errors++;
                end
            end
        end
    end

    // Hard stop should the block hang.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still owed",
                     cycle_count, awaited_results.size());
            $display("tb: failure");
            $finish;
        end
    end

    initial begin : run_tests
        int i;
        // shadow table starts empty, capacity at its reset value
        capacity_reg = CAP_RESET;
        live_count   = 0;
        for (i = 0; i < DEPTH; i++) begin
            slot_live[i] = 1'b0;
            slot_key[i]  = '0;
            slot_val[i]  = '0;
            slot_uses[i] = '0;
            slot_age[i]  = '0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basic_lookup();
        test_capacity_zero();
        test_lowered_capacity();
        test_random_traffic(22, 82);
        test_random_traffic(82, 22);
        test_random_traffic(0, 0);

        // let the last words out, then idle before the summary
        drain_results();
        repeat (DEPTH + 8) @(posedge i_clk);

        $display("summary: %0d words sent, %0d results checked, %0d hits, %0d evictions",
                 n_sent, n_checked, n_hits, n_evictions);
        $display("summary: capacities 0 to 31 incl. saturation, three sender/receiver stall mixes");
        if (n_errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
